### sv/avrsie_pkg.sv
// Shared types, constants and the instruction decoder of the AVR subset executor.
`timescale 1ns / 1ps

package avrsie_pkg;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_ADC,
        OP_SUB,
        OP_SUBI,
        OP_SBCI,
        OP_LDI,
        OP_OUT,
        OP_RJMP,
        OP_BRNE,
        OP_NOP,
        OP_UNKNOWN
    } op_t;

    localparam logic [5:0] PORTB_ADDR = 6'h18;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_N = 2;
    localparam int FLAG_V = 3;
    localparam int FLAG_S = 4;
    localparam int FLAG_H = 5;

    // register file write port
    typedef struct packed {
        logic       en;
        logic [4:0] addr;
        logic [7:0] data;
    } wr_t;

    // register file read request, issued with the input beat
    typedef struct packed {
        logic       en;
        logic [4:0] addr_a;
        logic [4:0] addr_b;
    } rd_req_t;

    // architectural values after one instruction
    typedef struct packed {
        logic [11:0] next_pc;
        logic [5:0]  pins;
        logic [7:0]  flags;
        logic        unknown;
    } res_t;

    function automatic op_t decode_op(input logic [15:0] w);
        op_t op;
        begin
            unique casez (w)
                16'b0000_11??_????_????: op = OP_ADD;
                16'b0001_11??_????_????: op = OP_ADC;
                16'b0001_10??_????_????: op = OP_SUB;
                16'b0101_????_????_????: op = OP_SUBI;
                16'b0100_????_????_????: op = OP_SBCI;
                16'b1110_????_????_????: op = OP_LDI;
                16'b1011_1???_????_????: op = OP_OUT;
                16'b1100_????_????_????: op = OP_RJMP;
                16'b1111_01??_????_?001: op = OP_BRNE;
                16'b0000_0000_0000_0000: op = OP_NOP;
                default:                 op = OP_UNKNOWN;
            endcase
            return op;
        end
    endfunction

    // immediate forms address R16..R31 through bits 7:4
    function automatic logic uses_high_reg(input op_t op);
        begin
            return (op == OP_SUBI) || (op == OP_SBCI) || (op == OP_LDI);
        end
    endfunction

endpackage

### sv/avrsie_regfile.sv
// 32 x 8 register file with registered two-port read and write bypass.
`timescale 1ns / 1ps

module avrsie_regfile
(
    input  logic               clk,
    input  logic               rst_n,
    input  avrsie_pkg::rd_req_t rd_req,
    input  avrsie_pkg::wr_t    wr,
    output logic [7:0]         rd_a,
    output logic [7:0]         rd_b
);

    logic [7:0]  mem [32];
    logic [31:0] valid_reg;
    logic [7:0]  rd_a_reg;
    logic [7:0]  rd_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk)
    begin
        if (rd_req.en)
        begin
            if (wr.en && wr.addr == rd_req.addr_a)
                rd_a_reg <= wr.data;
            else if (valid_reg[rd_req.addr_a])
                rd_a_reg <= mem[rd_req.addr_a];
            else
                rd_a_reg <= 8'h00;

            if (wr.en && wr.addr == rd_req.addr_b)
                rd_b_reg <= wr.data;
            else if (valid_reg[rd_req.addr_b])
                rd_b_reg <= mem[rd_req.addr_b];
            else
                rd_b_reg <= 8'h00;
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

### sv/avrsie_exec.sv
// Execute stage: ALU, flags, program counter and port latch of the AVR subset.
`timescale 1ns / 1ps

module avrsie_exec
#(
    parameter int PROGRAM_WORDS = 4096,
    parameter int PIN_COUNT     = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  avrsie_pkg::op_t      op,
    input  logic [15:0]          instr,
    input  logic [7:0]           opa,
    input  logic [7:0]           opb,
    output avrsie_pkg::wr_t      wr,
    output avrsie_pkg::res_t     res
);

    // bias keeps pc + 1 + offset non-negative and a multiple of the program size
    localparam int BIAS   = PROGRAM_WORDS * ((2048 + PROGRAM_WORDS - 1) / PROGRAM_WORDS);
    localparam int UMAX   = 4095 + 1 + 2047 + BIAS;
    localparam int UW     = $clog2(UMAX + 1);
    localparam int SH     = UW + $clog2(PROGRAM_WORDS);
    localparam int PRODW  = 2 * UW + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + longint'(PROGRAM_WORDS) - 64'd1) / longint'(PROGRAM_WORDS);
    localparam logic [5:0] PIN_MASK = 6'(((1 << PIN_COUNT) - 1) & 'h3F);

    logic [11:0] pc_reg;
    logic [7:0]  flags_reg;
    logic [5:0]  pins_reg;

    logic [4:0]  d5;
    logic [4:0]  dh;
    logic [7:0]  k8;
    logic [5:0]  io_addr;
    logic        is_alu;
    logic        is_sub;
    logic        use_imm;
    logic        cin;
    logic [7:0]  b;
    logic [7:0]  r;
    logic [7:0]  cv;
    logic [7:0]  ov;
    logic        z_new;
    logic [7:0]  flags_alu;
    logic signed [11:0] offset;
    logic [UW-1:0]    u;
    logic [PRODW-1:0] prod;
    logic [UW-1:0]    q;
    logic [UW-1:0]    rem;
    logic [11:0] pc_next;
    logic [7:0]  flags_next;
    logic [5:0]  pins_next;

    assign d5      = instr[8:4];
    assign dh      = {1'b1, instr[7:4]};
    assign k8      = {instr[11:8], instr[3:0]};
    assign io_addr = {instr[10:9], instr[3:0]};

    assign is_alu  = (op == avrsie_pkg::OP_ADD) || (op == avrsie_pkg::OP_ADC)
                  || (op == avrsie_pkg::OP_SUB) || (op == avrsie_pkg::OP_SUBI)
                  || (op == avrsie_pkg::OP_SBCI);
    assign is_sub  = (op == avrsie_pkg::OP_SUB) || (op == avrsie_pkg::OP_SUBI)
                  || (op == avrsie_pkg::OP_SBCI);
    assign use_imm = avrsie_pkg::uses_high_reg(op);
    assign cin     = ((op == avrsie_pkg::OP_ADC) || (op == avrsie_pkg::OP_SBCI))
                  & flags_reg[avrsie_pkg::FLAG_C];
    assign b       = use_imm ? k8 : opb;

    always_comb
    begin
        if (is_sub)
        begin
            r  = 8'(opa - b - 8'(cin));
            cv = (~opa & b) | (b & r) | (r & ~opa);
            ov = (opa & ~b & ~r) | (~opa & b & r);
        end
        else
        begin
            r  = 8'(opa + b + 8'(cin));
            cv = (opa & b) | (b & ~r) | (~r & opa);
            ov = (opa & b & ~r) | (~opa & ~b & r);
        end
    end

    // SBCI keeps Z only when it was already set
    assign z_new = (r == 8'h00)
                && ((op != avrsie_pkg::OP_SBCI) || flags_reg[avrsie_pkg::FLAG_Z]);

    assign flags_alu = {flags_reg[7:6], cv[3], r[7] ^ ov[7], ov[7], r[7], z_new, cv[7]};

    always_comb
    begin
        case (op)
            avrsie_pkg::OP_RJMP: offset = $signed(instr[11:0]);
            avrsie_pkg::OP_BRNE: offset = flags_reg[avrsie_pkg::FLAG_Z]
                                          ? 12'sd0 : 12'($signed(instr[9:3]));
            default:             offset = 12'sd0;
        endcase
    end

    // (pc + 1 + offset) mod PROGRAM_WORDS via exact reciprocal
    assign u       = UW'(BIAS + 1) + UW'(pc_reg) + UW'(offset);
    assign prod    = PRODW'(u) * PRODW'(RECIP);
    assign q       = UW'(prod >> SH);
    assign rem     = u - UW'(q * UW'(PROGRAM_WORDS));
    assign pc_next = rem[11:0];

    assign flags_next = is_alu ? flags_alu : flags_reg;
    assign pins_next  = ((op == avrsie_pkg::OP_OUT) && (io_addr == avrsie_pkg::PORTB_ADDR))
                        ? (opa[5:0] & PIN_MASK) : pins_reg;

    assign wr.en   = go && (is_alu || (op == avrsie_pkg::OP_LDI));
    assign wr.addr = use_imm ? dh : d5;
    assign wr.data = (op == avrsie_pkg::OP_LDI) ? k8 : r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= '0;
            flags_reg <= '0;
            pins_reg  <= '0;
        end
        else if (go)
        begin
            pc_reg    <= pc_next;
            flags_reg <= flags_next;
            pins_reg  <= pins_next;
        end
    end

    assign res.next_pc = pc_next;
    assign res.pins    = pins_next;
    assign res.flags   = flags_next;
    assign res.unknown = (op == avrsie_pkg::OP_UNKNOWN);

    a_unknown_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        go && (op == avrsie_pkg::OP_UNKNOWN) |=> $stable(flags_reg) && $stable(pins_reg))
        else $error("unknown word changed flags or pins");

    a_ldi_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        go && (op == avrsie_pkg::OP_LDI) |=> $stable(flags_reg))
        else $error("LDI changed flags");

endmodule

### sv/avr_subset_instruction_execute.sv
// Top level of the AVR subset instruction executor.
//
// Input channel: one 16-bit instruction word per beat (in_valid / in_stall).
// Output channel: one beat per instruction (out_valid / out_stall) carrying the
// next fetch address, the port pin levels, the status flags and a flag for
// words outside the supported subset.
// A word is latched into the input register together with its two register
// file operands, executed once the output register is free or being taken,
// and its result captured in the output register.
// Throughput is one instruction per cycle while out_stall is low; register,
// flag and PC dependences between consecutive words resolve through the write
// bypass of the register file and the state registers of the execute stage.
// While out_stall holds a result, one more word may wait in the input
// register; after that in_stall rises until the result is taken.
// Reset clears the registers, flags, PC and pins to zero and empties both
// pipeline registers.
`timescale 1ns / 1ps

module avr_subset_instruction_execute
#(
    parameter int PROGRAM_WORDS = 4096,
    parameter int PIN_COUNT     = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] instruction,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] next_pc,
    output logic [5:0]  port_pins,
    output logic [7:0]  status_flags,
    output logic        unknown_instruction
);

    logic               ir_valid_reg;
    logic [15:0]        ir_instr_reg;
    avrsie_pkg::op_t    ir_op_reg;
    logic               ov_valid_reg;
    avrsie_pkg::res_t   res_reg;

    logic               in_accept;
    logic               exec_go;
    avrsie_pkg::op_t    in_op;
    avrsie_pkg::rd_req_t rd_req;
    avrsie_pkg::wr_t    wr;
    avrsie_pkg::res_t   res;
    logic [7:0]         opa;
    logic [7:0]         opb;

    assign exec_go   = ir_valid_reg && (!ov_valid_reg || !out_stall);
    assign in_stall  = ir_valid_reg && ov_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign in_op         = avrsie_pkg::decode_op(instruction);
    assign rd_req.en     = in_accept;
    assign rd_req.addr_a = avrsie_pkg::uses_high_reg(in_op)
                           ? {1'b1, instruction[7:4]} : instruction[8:4];
    assign rd_req.addr_b = {instruction[9], instruction[3:0]};

    avrsie_regfile u_regfile
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_req (rd_req),
        .wr     (wr),
        .rd_a   (opa),
        .rd_b   (opb)
    );

    avrsie_exec
    #(
        .PROGRAM_WORDS (PROGRAM_WORDS),
        .PIN_COUNT     (PIN_COUNT)
    )
    u_exec
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (exec_go),
        .op    (ir_op_reg),
        .instr (ir_instr_reg),
        .opa   (opa),
        .opb   (opb),
        .wr    (wr),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg <= 1'b0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                ir_valid_reg <= 1'b1;
            else if (exec_go)
                ir_valid_reg <= 1'b0;

            if (exec_go)
                ov_valid_reg <= 1'b1;
            else if (!out_stall)
                ov_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ir_instr_reg <= instruction;
            ir_op_reg    <= in_op;
        end
        if (exec_go)
        begin
            res_reg <= res;
        end
    end

    assign out_valid           = ov_valid_reg;
    assign next_pc             = res_reg.next_pc;
    assign port_pins           = res_reg.pins;
    assign status_flags        = res_reg.flags;
    assign unknown_instruction = res_reg.unknown;

    a_exec_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> out_valid)
        else $error("executed beat did not reach the output register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ir_valid_reg && ov_valid_reg)
        else $error("input stalled with a free pipeline slot");

    a_held_word_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ir_valid_reg && !exec_go |=> ir_valid_reg && $stable(ir_instr_reg))
        else $error("waiting instruction lost");

endmodule
